// ===== src/utf8d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types for the UTF-8 byte stream decoder: status codes, decoder state
// and the per-byte step result.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CP_W      = 31;
  localparam int unsigned PEND_W    = 3;
  localparam int unsigned TDATA_W   = 32;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [PEND_W-1:0] pending;
    logic [CP_W-1:0]   partial;
    logic              discarding;
  } dec_state_t;

  typedef struct packed {
    logic            emit;
    logic [CP_W-1:0] code_point;
    status_t         status;
    logic            string_end;
  } step_res_t;

endpackage

// ===== src/utf8d_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_step
// Combinational decode of one byte: lead classification, continuation
// accumulation, error and end-of-string handling, next decoder state.
// ----------------------------------------------------------------------------
module utf8d_step (
  input  utf8d_pkg::dec_state_t cur_state,
  input  logic [7:0]            data_byte,
  input  logic                  string_last,
  output utf8d_pkg::dec_state_t nxt_state,
  output utf8d_pkg::step_res_t  res
);
  import utf8d_pkg::*;

  logic              lead_ok;
  logic [PEND_W-1:0] lead_more;
  logic [CP_W-1:0]   lead_bits;
  logic [CP_W-1:0]   acc_value;
  logic [PEND_W-1:0] acc_pending;

  always_comb begin
    lead_ok   = 1'b1;
    lead_more = '0;
    lead_bits = '0;
    priority if ((data_byte & 8'h80) == 8'h00) begin
      lead_more = 3'd0;
      lead_bits = CP_W'(data_byte & 8'h7F);
    end else if ((data_byte & 8'hE0) == 8'hC0) begin
      lead_more = 3'd1;
      lead_bits = CP_W'(data_byte & 8'h1F);
    end else if ((data_byte & 8'hF0) == 8'hE0) begin
      lead_more = 3'd2;
      lead_bits = CP_W'(data_byte & 8'h0F);
    end else if ((data_byte & 8'hF8) == 8'hF0) begin
      lead_more = 3'd3;
      lead_bits = CP_W'(data_byte & 8'h07);
    end else if ((data_byte & 8'hFC) == 8'hF8) begin
      lead_more = 3'd4;
      lead_bits = CP_W'(data_byte & 8'h03);
    end else if ((data_byte & 8'hFE) == 8'hFC) begin
      lead_more = 3'd5;
      lead_bits = CP_W'(data_byte & 8'h01);
    end else begin
      lead_ok = 1'b0;
    end
  end

  assign acc_value   = {cur_state.partial[CP_W-7:0], data_byte[5:0]};
  assign acc_pending = cur_state.pending - 3'd1;

  always_comb begin
    nxt_state      = cur_state;
    res.emit       = 1'b0;
    res.code_point = '0;
    res.status     = STATUS_OK;
    res.string_end = string_last;
    if (cur_state.discarding) begin
      if (string_last) begin
        nxt_state = '0;
      end
    end else if (cur_state.pending == '0) begin
      if (!lead_ok) begin
        nxt_state            = '0;
        nxt_state.discarding = !string_last;
        res.emit             = 1'b1;
        res.status           = STATUS_INVALID;
      end else if (lead_more == '0) begin
        res.emit       = 1'b1;
        res.code_point = lead_bits;
      end else if (string_last) begin
        nxt_state  = '0;
        res.emit   = 1'b1;
        res.status = STATUS_TRUNCATED;
      end else begin
        nxt_state.pending = lead_more;
        nxt_state.partial = lead_bits;
      end
    end else begin
      if (acc_pending == '0) begin
        nxt_state      = '0;
        res.emit       = 1'b1;
        res.code_point = acc_value;
      end else if (string_last) begin
        nxt_state  = '0;
        res.emit   = 1'b1;
        res.status = STATUS_TRUNCATED;
      end else begin
        nxt_state.pending = acc_pending;
        nxt_state.partial = acc_value;
      end
    end
  end

endmodule

// ===== src/utf8_byte_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_unit
// Streaming decoder for 31-bit UTF-8, one byte in, at most one code point out.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle, sustained, as long as the result side
// keeps up. Each byte passes through an input register, is decoded
// combinationally against the sequence state, and any result lands in the
// output register. Lead bytes open sequences of 1 to 6 bytes; continuation
// bytes contribute their low 6 bits unchecked. A stray continuation byte or
// 0xFE/0xFF at lead gives status 1, a string ending inside a sequence gives
// status 2, and after an error bytes are dropped silently through the end of
// the string.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // string_last
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [utf8d_pkg::TDATA_W-1:0]  out_tdata,  // [30:0] code_point, [31] zero
  output logic [1:0]                     out_tuser,  // [1:0] status
  output logic                           out_tlast   // string_end
);
  import utf8d_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       advance;

  dec_state_t state_r;
  dec_state_t state_nxt;
  step_res_t  res;

  logic            out_valid_r;
  logic [CP_W-1:0] out_cp_r;
  status_t         out_status_r;
  logic            out_last_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  utf8d_step u_step (
    .cur_state   (state_r),
    .data_byte   (in_byte_r),
    .string_last (in_last_r),
    .nxt_state   (state_nxt),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance) begin
        out_valid_r <= res.emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_cp_r     <= res.code_point;
      out_status_r <= res.status;
      out_last_r   <= res.string_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cp_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
